/* sv/skl_pkg.sv */
package skl_pkg;

  // Default keypad size
  localparam int BUTTON_COUNT_DEF = 4;

  // Generator and draw widths
  localparam int GEN_W = 32;
  localparam int MOD_W = 5;
  localparam int CHAR_W = 8;
  localparam int SLOT_COUNT = 4;

  // Input action codes
  localparam logic ACT_SEED     = 1'b0;
  localparam logic ACT_SCRAMBLE = 1'b1;

  // Character class slots
  localparam logic [1:0] SLOT_DIGIT   = 2'd0;
  localparam logic [1:0] SLOT_UPPER   = 2'd1;
  localparam logic [1:0] SLOT_LOWER   = 2'd2;
  localparam logic [1:0] SLOT_SPECIAL = 2'd3;

  // Pool sizes
  localparam logic [MOD_W-1:0] DigitLen   = 5'd10;
  localparam logic [MOD_W-1:0] UpperLen   = 5'd26;
  localparam logic [MOD_W-1:0] LowerLen   = 5'd26;
  localparam logic [MOD_W-1:0] SpecialLen = 5'd31;

  // Special pool, first character in the top byte
  localparam logic [8*31-1:0] SPECIAL_POOL = "!@#$%^&*()_+-=[]{}|;':\",./<>?\\~";

  // Request from the sequencer to the draw unit
  typedef struct packed {
    logic             start;
    logic             load;
    logic [GEN_W-1:0] seed;
    logic [MOD_W-1:0] modulus;
  } skl_draw_req_t;

  // Answer from the draw unit
  typedef struct packed {
    logic             done;
    logic [MOD_W-1:0] value;
  } skl_draw_rsp_t;

  function automatic logic [1:0] class_of(input logic [CHAR_W-1:0] c);
    logic [1:0] cls;
    if (c >= 8'h30 && c <= 8'h39) cls = SLOT_DIGIT;
    else if (c >= 8'h41 && c <= 8'h5a) cls = SLOT_UPPER;
    else if (c >= 8'h61 && c <= 8'h7a) cls = SLOT_LOWER;
    else cls = SLOT_SPECIAL;
    return cls;
  endfunction

  function automatic logic [MOD_W-1:0] pool_len(input logic [1:0] slot);
    logic [MOD_W-1:0] len;
    case (slot)
      SLOT_DIGIT: len = DigitLen;
      SLOT_UPPER: len = UpperLen;
      SLOT_LOWER: len = LowerLen;
      default:    len = SpecialLen;
    endcase
    return len;
  endfunction

  function automatic logic [CHAR_W-1:0] pool_char(input logic [1:0] slot,
                                                  input logic [MOD_W-1:0] idx);
    logic [CHAR_W-1:0] c;
    logic [MOD_W-1:0] pos;
    pos = SpecialLen - 5'd1 - idx;
    case (slot)
      SLOT_DIGIT: c = 8'h30 + {3'b000, idx};
      SLOT_UPPER: c = 8'h41 + {3'b000, idx};
      SLOT_LOWER: c = 8'h61 + {3'b000, idx};
      default:    c = SPECIAL_POOL[{pos, 3'b000} +: 8];
    endcase
    return c;
  endfunction

endpackage

/* sv/skl_if.sv */
interface skl_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] seed_value;
  logic [7:0]  expected_char;

  modport source (output valid, action, seed_value, expected_char, input ready);
  modport sink (input valid, action, seed_value, expected_char, output ready);
endinterface

interface skl_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] button_index;
  logic [7:0] slot_char_zero;
  logic [7:0] slot_char_one;
  logic [7:0] slot_char_two;
  logic [7:0] slot_char_three;
  logic       last_button;

  modport source (output valid, button_index, slot_char_zero, slot_char_one,
                  slot_char_two, slot_char_three, last_button, input ready);
  modport sink (input valid, button_index, slot_char_zero, slot_char_one,
                slot_char_two, slot_char_three, last_button, output ready);
endinterface

/* sv/scrambled_keypad_layout.sv */
// Channel   Dir  Transfer when         Payload
// in_chan   in   valid & ready         action, seed_value, expected_char
// out_chan  out  valid & ready         button_index, slot_char_zero..three, last_button
//
// A scramble item runs every draw through one shared xorshift and remainder unit:
// issue and step, four byte folds, hand back. A layout is the transfer in, then seven
// draws and one handoff per button; an expected character adds a draw to pick its
// button and spares that button's draw for its class, and each redraw adds one.
// in_chan is ready only while idle; a finished button waits in the output register
// while the next one is drawn. Reset is synchronous and loads the generator with one.
module scrambled_keypad_layout #(
  parameter int BUTTON_COUNT = skl_pkg::BUTTON_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  skl_in_if.sink    in_chan,
  skl_out_if.source out_chan
);

  localparam int BW = $clog2(BUTTON_COUNT);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PICK  = 5'b00010,
    ST_SLOT  = 5'b00100,
    ST_SHUF  = 5'b01000,
    ST_FLUSH = 5'b10000
  } skl_state_t;

  skl_state_t state_r, state_nxt;
  logic                       wait_r, wait_nxt;
  logic [7:0]                 exp_r, exp_nxt;
  logic [1:0]                 cls_r, cls_nxt;
  logic [BW-1:0]              correct_r, correct_nxt;
  logic [BW-1:0]              btn_r, btn_nxt;
  logic [1:0]                 slot_r, slot_nxt;
  logic [1:0]                 k_r, k_nxt;
  logic [7:0]                 chars_r [skl_pkg::SLOT_COUNT];
  logic [7:0]                 chars_nxt [skl_pkg::SLOT_COUNT];
  logic                       out_valid_r, out_valid_nxt;
  logic [1:0]                 out_idx_r;
  logic [7:0]                 out_c0_r, out_c1_r, out_c2_r, out_c3_r;
  logic                       out_last_r;
  logic                       load_out;
  logic                       skip;
  logic                       last_btn;
  logic [7:0]                 drawn;
  logic [1:0]                 j;
  logic [3:0]                 btn_ext;
  skl_pkg::skl_draw_req_t     req;
  skl_pkg::skl_draw_rsp_t     rsp;

  skl_draw_unit u_draw (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (req),
    .rsp  (rsp)
  );

  assign in_chan.ready = (state_r == ST_IDLE);
  assign skip = (exp_r != 8'd0) && (btn_r == correct_r) && (slot_r == cls_r);
  assign last_btn = (btn_r == BW'(BUTTON_COUNT - 1));
  assign drawn = skl_pkg::pool_char(slot_r, rsp.value);
  assign j = rsp.value[1:0];
  assign btn_ext = 4'(btn_r);

  // Sequence draws for one layout
  always_comb begin
    state_nxt = state_r;
    wait_nxt = wait_r;
    exp_nxt = exp_r;
    cls_nxt = cls_r;
    correct_nxt = correct_r;
    btn_nxt = btn_r;
    slot_nxt = slot_r;
    k_nxt = k_r;
    for (int i = 0; i < skl_pkg::SLOT_COUNT; i++) chars_nxt[i] = chars_r[i];
    load_out = 1'b0;
    req.start = 1'b0;
    req.load = 1'b0;
    req.seed = in_chan.seed_value;
    req.modulus = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          if (in_chan.action == skl_pkg::ACT_SEED) begin
            req.load = 1'b1;
          end else begin
            exp_nxt = in_chan.expected_char;
            cls_nxt = skl_pkg::class_of(in_chan.expected_char);
            correct_nxt = '0;
            btn_nxt = '0;
            slot_nxt = '0;
            wait_nxt = 1'b0;
            state_nxt = (in_chan.expected_char != 8'd0) ? ST_PICK : ST_SLOT;
          end
        end
      end
      ST_PICK: begin
        req.modulus = 5'(BUTTON_COUNT);
        req.start = !wait_r;
        if (!wait_r) begin
          wait_nxt = 1'b1;
        end else if (rsp.done) begin
          correct_nxt = BW'(rsp.value);
          wait_nxt = 1'b0;
          state_nxt = ST_SLOT;
        end
      end
      ST_SLOT: begin
        req.modulus = skl_pkg::pool_len(slot_r);
        req.start = !wait_r && !skip;
        if (skip) begin
          chars_nxt[slot_r] = exp_r;
          if (slot_r == 2'd3) begin
            k_nxt = 2'd3;
            state_nxt = ST_SHUF;
          end else begin
            slot_nxt = slot_r + 2'd1;
          end
        end else if (!wait_r) begin
          wait_nxt = 1'b1;
        end else if (rsp.done) begin
          wait_nxt = 1'b0;
          // Redraw on a hit of the expected character
          if (drawn != exp_r) begin
            chars_nxt[slot_r] = drawn;
            if (slot_r == 2'd3) begin
              k_nxt = 2'd3;
              state_nxt = ST_SHUF;
            end else begin
              slot_nxt = slot_r + 2'd1;
            end
          end
        end
      end
      ST_SHUF: begin
        req.modulus = 5'(k_r) + 5'd1;
        req.start = !wait_r;
        if (!wait_r) begin
          wait_nxt = 1'b1;
        end else if (rsp.done) begin
          wait_nxt = 1'b0;
          chars_nxt[k_r] = chars_r[j];
          chars_nxt[j] = chars_r[k_r];
          if (k_r == 2'd1) state_nxt = ST_FLUSH;
          else k_nxt = k_r - 2'd1;
        end
      end
      ST_FLUSH: begin
        if (!out_valid_r || out_chan.ready) begin
          load_out = 1'b1;
          if (last_btn) begin
            state_nxt = ST_IDLE;
          end else begin
            btn_nxt = btn_r + BW'(1);
            slot_nxt = '0;
            state_nxt = ST_SLOT;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold a result until its transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) out_valid_nxt = 1'b1;
    else if (out_chan.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      wait_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wait_r <= wait_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    exp_r <= exp_nxt;
    cls_r <= cls_nxt;
    correct_r <= correct_nxt;
    btn_r <= btn_nxt;
    slot_r <= slot_nxt;
    k_r <= k_nxt;
    for (int i = 0; i < skl_pkg::SLOT_COUNT; i++) chars_r[i] <= chars_nxt[i];
    if (load_out) begin
      out_idx_r <= btn_ext[1:0];
      out_c0_r <= chars_r[0];
      out_c1_r <= chars_r[1];
      out_c2_r <= chars_r[2];
      out_c3_r <= chars_r[3];
      out_last_r <= last_btn;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.button_index = out_idx_r;
  assign out_chan.slot_char_zero = out_c0_r;
  assign out_chan.slot_char_one = out_c1_r;
  assign out_chan.slot_char_two = out_c2_r;
  assign out_chan.slot_char_three = out_c3_r;
  assign out_chan.last_button = out_last_r;

endmodule

/* sv/skl_draw_unit.sv */
module skl_draw_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  skl_pkg::skl_draw_req_t req,
  output skl_pkg::skl_draw_rsp_t rsp
);

  logic [skl_pkg::GEN_W-1:0] gen_r, gen_nxt;
  logic [skl_pkg::GEN_W-1:0] shuffled;
  logic [skl_pkg::MOD_W-1:0] n_r;
  logic [skl_pkg::MOD_W-1:0] rem_r, rem_nxt;
  logic [1:0]                byte_idx_r;
  logic                      busy_r;
  logic                      done_r;
  logic [7:0]                cur_byte;
  logic [12:0]               part;
  logic [12:0]               sub;

  // xorshift 13 / 17 / 5 step
  always_comb begin
    shuffled = gen_r ^ (gen_r << 13);
    shuffled = shuffled ^ (shuffled >> 17);
    shuffled = shuffled ^ (shuffled << 5);
  end

  // Fold one byte of the state into the remainder, most significant byte first
  always_comb begin
    cur_byte = gen_r[{byte_idx_r, 3'b000} +: 8];
    part = {rem_r, cur_byte};
    for (int i = 7; i >= 0; i--) begin
      sub = 13'(n_r) << i;
      if (part >= sub) part = part - sub;
    end
    rem_nxt = part[skl_pkg::MOD_W-1:0];
  end

  always_comb begin
    gen_nxt = gen_r;
    if (req.load) gen_nxt = (req.seed == '0) ? 32'd1 : req.seed;
    else if (req.start) gen_nxt = shuffled;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r <= 32'd1;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      gen_r <= gen_nxt;
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        byte_idx_r <= 2'd3;
        rem_r <= '0;
        n_r <= req.modulus;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        byte_idx_r <= byte_idx_r - 2'd1;
        if (byte_idx_r == 2'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.value = rem_r;

endmodule

/* sim/keypad_layout_checker.sv */
`timescale 1ns / 1ps

module keypad_layout_checker #(
  parameter int BUTTONS = skl_pkg::BUTTON_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  skl_in_if           in_mon,
  skl_out_if          out_mon,
  output int unsigned fail_count,
  output int unsigned pending_rows,
  output int unsigned rows_checked
);

  // One button of a predicted layout
  typedef struct packed {
    logic [1:0] button_index;
    logic [7:0] char_zero;
    logic [7:0] char_one;
    logic [7:0] char_two;
    logic [7:0] char_three;
    logic       last_button;
  } keypad_row_t;

  // Special characters, first one in the top byte
  localparam logic [8*31-1:0] SPECIAL_SET = "!@#$%^&*()_+-=[]{}|;':\",./<>?\\~";

  logic [31:0]  gen_state;
  keypad_row_t  layout_rows[$];
  int unsigned  errs;
  int unsigned  checked;

  initial begin
    gen_state = 32'd1;
    errs      = 0;
    checked   = 0;
  end

  // Step the xorshift and reduce the new state modulo n
  function automatic int unsigned next_draw(input int unsigned n);
    logic [31:0] s;
    s = gen_state;
    s = s ^ (s << 13);
    s = s ^ (s >> 17);
    s = s ^ (s << 5);
    gen_state = s;
    return s % n;
  endfunction

  function automatic logic [1:0] char_class(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return skl_pkg::SLOT_DIGIT;
    if (c >= 8'h41 && c <= 8'h5a) return skl_pkg::SLOT_UPPER;
    if (c >= 8'h61 && c <= 8'h7a) return skl_pkg::SLOT_LOWER;
    return skl_pkg::SLOT_SPECIAL;
  endfunction

  function automatic int unsigned pool_size(input logic [1:0] slot);
    case (slot)
      skl_pkg::SLOT_DIGIT: return 10;
      skl_pkg::SLOT_UPPER: return 26;
      skl_pkg::SLOT_LOWER: return 26;
      default:             return 31;
    endcase
  endfunction

  function automatic logic [7:0] pool_pick(input logic [1:0] slot, input int unsigned idx);
    logic [7:0] offs;
    offs = idx[7:0];
    case (slot)
      skl_pkg::SLOT_DIGIT: return 8'h30 + offs;
      skl_pkg::SLOT_UPPER: return 8'h41 + offs;
      skl_pkg::SLOT_LOWER: return 8'h61 + offs;
      default:             return SPECIAL_SET[8*(30-idx) +: 8];
    endcase
  endfunction

  // Draw a whole layout and queue one row per button
  function automatic void draw_layout(input logic [7:0] want_ch);
    logic [7:0]  slots [4];
    logic [7:0]  pick;
    logic [7:0]  tmp;
    logic [1:0]  want_slot;
    logic        forced;
    int unsigned hit_button;
    int unsigned j;
    int          b;
    int          s;
    int          k;
    keypad_row_t row;
    hit_button = 0;
    want_slot  = char_class(want_ch);
    if (want_ch != 8'h00) hit_button = next_draw(BUTTONS);
    for (b = 0; b < BUTTONS; b++) begin
      // Fill the class slots, keeping the expected character off other slots
      for (s = 0; s < 4; s++) begin
        forced = (want_ch != 8'h00) && (b == hit_button) && (s == want_slot);
        if (forced) begin
          slots[s] = want_ch;
        end else begin
          do begin
            pick = pool_pick(s[1:0], next_draw(pool_size(s[1:0])));
          end while (pick == want_ch);
          slots[s] = pick;
        end
      end
      // Shuffle the four characters of this button
      for (k = 3; k > 0; k--) begin
        j        = next_draw(k + 1) & 3;
        tmp      = slots[k];
        slots[k] = slots[j];
        slots[j] = tmp;
      end
      row.button_index = b[1:0];
      row.char_zero    = slots[0];
      row.char_one     = slots[1];
      row.char_two     = slots[2];
      row.char_three   = slots[3];
      row.last_button  = (b == BUTTONS - 1);
      layout_rows.push_back(row);
    end
  endfunction

  function automatic void check_field(input string field, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      errs++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
    end
  endfunction

  // Watch both channels, predict on input transfers, compare on output transfers
  always @(posedge clk) begin
    keypad_row_t want;
    if (!rst_n) begin
      gen_state = 32'd1;
      layout_rows.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.action == skl_pkg::ACT_SEED) begin
          gen_state = (in_mon.seed_value == 32'd0) ? 32'd1 : in_mon.seed_value;
        end else begin
          draw_layout(in_mon.expected_char);
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        if (layout_rows.size() == 0) begin
          errs++;
          $display("%0t: unexpected row, expected none actual button %0d chars %h %h %h %h",
                   $time, out_mon.button_index, out_mon.slot_char_zero,
                   out_mon.slot_char_one, out_mon.slot_char_two, out_mon.slot_char_three);
        end else begin
          want = layout_rows.pop_front();
          checked++;
          check_field("button_index", {6'd0, want.button_index}, {6'd0, out_mon.button_index});
          check_field("slot_char_zero", want.char_zero, out_mon.slot_char_zero);
          check_field("slot_char_one", want.char_one, out_mon.slot_char_one);
          check_field("slot_char_two", want.char_two, out_mon.slot_char_two);
          check_field("slot_char_three", want.char_three, out_mon.slot_char_three);
          check_field("last_button", {7'd0, want.last_button}, {7'd0, out_mon.last_button});
        end
      end
    end
    fail_count   <= errs;
    pending_rows <= layout_rows.size();
    rows_checked <= checked;
  end

endmodule

/* sim/scrambled_keypad_layout_tb.sv */
`timescale 1ns / 1ps

module scrambled_keypad_layout_tb;

  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 200;

  logic        clk;
  logic        rst_n;
  logic        calm;
  int unsigned fail_count;
  int unsigned pending_rows;
  int unsigned rows_checked;
  int unsigned seeds_sent;
  int unsigned layouts_sent;
  int unsigned quiet_cycles;

  skl_in_if  in_chan();
  skl_out_if out_chan();

  scrambled_keypad_layout u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  keypad_layout_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_chan),
    .out_mon      (out_chan),
    .fail_count   (fail_count),
    .pending_rows (pending_rows),
    .rows_checked (rows_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one item after a random gap and hold it until the transfer
  task automatic offer_item(input logic act, input logic [31:0] seed, input logic [7:0] want);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.action        <= act;
    in_chan.seed_value    <= seed;
    in_chan.expected_char <= want;
    do @(posedge clk); while (!in_chan.ready);
    if (act == skl_pkg::ACT_SEED) seeds_sent++;
    else layouts_sent++;
  endtask

  // Unused fields carry random values so every bit toggles
  task automatic load_seed(input logic [31:0] seed);
    offer_item(skl_pkg::ACT_SEED, seed, 8'($urandom_range(0, 255)));
  endtask

  task automatic scramble(input logic [7:0] want);
    offer_item(skl_pkg::ACT_SCRAMBLE, $urandom, want);
  endtask

  // Stop offering until every predicted row has come out
  task automatic drain_layouts();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (pending_rows != 0);
  endtask

  function automatic logic [7:0] rand_char();
    case ($urandom_range(0, 4))
      0:       return 8'h00;
      1:       return 8'h30 + 8'($urandom_range(0, 9));
      2:       return 8'h41 + 8'($urandom_range(0, 25));
      3:       return 8'h61 + 8'($urandom_range(0, 25));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [31:0] rand_seed();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Stimulus and verdict
  initial begin
    int phase;
    int n;
    rst_n                 = 1'b0;
    calm                  = 1'b0;
    seeds_sent            = 0;
    layouts_sent          = 0;
    in_chan.valid         = 1'b0;
    in_chan.action        = skl_pkg::ACT_SEED;
    in_chan.seed_value    = 32'd0;
    in_chan.expected_char = 8'h00;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset seed, zero seed, class boundaries, high codes
    scramble(8'h00);
    load_seed(32'h0000_0000);
    scramble(8'h30);
    load_seed(32'hFFFF_FFFF);
    scramble(8'h39);
    scramble(8'h41);
    scramble(8'h5A);
    scramble(8'h61);
    scramble(8'h7A);
    scramble(8'h21);
    scramble(8'h7E);
    scramble(8'h5C);
    scramble(8'hFF);
    scramble(8'h80);
    load_seed(32'h8000_0000);
    scramble(8'h01);
    scramble(8'h7F);
    scramble(8'h2F);
    scramble(8'h3A);
    scramble(8'h40);
    scramble(8'h5B);
    scramble(8'h60);
    scramble(8'h7B);
    load_seed(32'h1234_5678);
    load_seed(32'h0000_0001);
    scramble(8'h00);
    drain_layouts();

    // Random phases, some without idling, with pauses until drained
    for (phase = 0; phase < 8; phase++) begin
      calm = (phase == 2 || phase == 5);
      for (n = 0; n < 51; n++) begin
        if ($urandom_range(0, 99) < 15) load_seed(rand_seed());
        else scramble(rand_char());
      end
      if (phase == 1 || phase == 3 || phase == 6) drain_layouts();
    end
    calm = 1'b0;

    // Drain and let the block settle
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (pending_rows != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d seed loads and %0d layouts; %0d button rows compared.",
             seeds_sent, layouts_sent, rows_checked);
    $display("Covered class boundaries, zero and extreme seeds, and output back-pressure.");
    if (fail_count == 0 && pending_rows == 0) begin
      $display("scrambled_keypad_layout_tb: done, clean");
    end else begin
      $display("scrambled_keypad_layout_tb: done, errors");
    end
    $finish;
  end

  // Receiver: random stalls per row, two long hold-offs
  initial begin
    int unsigned got;
    int unsigned stall;
    got            = 0;
    out_chan.ready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (got == 60 || got == 700) begin
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = calm ? 0 : $urandom_range(0, 18);
      if (stall != 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
      got++;
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles = 0;
    end else begin
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("scrambled_keypad_layout_tb: done, errors");
        $finish;
      end
    end
  end

endmodule
